@@ design/bls_pkg.sv @@
// ============================================================================
// bls_pkg: shared types and constants of the bilinear RGB sampler
// Pixel layout, channel extraction, register indexes and the control
// structs that the pipeline modules exchange.
// ============================================================================
package bls_pkg;

   localparam int CHAN_W         = 8;
   localparam int COLOR_CHANNELS = 3;
   localparam int PIXEL_W        = CHAN_W * COLOR_CHANNELS;
   localparam int COORD_W        = 16;
   localparam int INDEX_W        = 16;
   localparam int DIM_W          = 9;
   localparam int OUT_W          = 16;
   localparam int QOUT_FRAC      = 8;
   localparam int NUM_NEIGHBORS  = 4;
   localparam int NUM_STAGES     = 6;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = CSR_INDEX_W'(1);

   // Item kinds carried by the mode field.
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // Load enables of the address stages.
   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } addr_ctl_type;

   // Load enables of the blend stages.
   typedef struct packed {
      logic s4_en;
      logic s5_en;
      logic s6_en;
   } blend_ctl_type;

   // What the word in the address stage three is.
   typedef struct packed {
      logic is_sample;
      logic wr_ok;
   } s3_status_type;

   // Channel 0 is red in the top byte, the last channel is blue.
   function automatic logic [CHAN_W-1:0] channel_of(input pixel_type px, input int ch);
      return px[CHAN_W*(COLOR_CHANNELS-1-ch) +: CHAN_W];
   endfunction

endpackage

@@ design/bls_pixel_bank.sv @@
// ============================================================================
// bls_pixel_bank: one copy of the pixel store
// One write port and one read port with a registered read word.
// ============================================================================
module bls_pixel_bank
   import bls_pkg::*;
#(
   parameter int DEPTH = 65536,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pixel_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output pixel_type         rd_data
);

   pixel_type mem [DEPTH];
   pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bls_addr_gen.sv @@
// ============================================================================
// bls_addr_gen: coordinate split and neighbor address stages
// Stages one to three: capture the word, form row times width and the range
// flags, then the four neighbor addresses and the combined range check.
// ============================================================================
module bls_addr_gen
   import bls_pkg::*;
#(
   parameter int IMAGE_PIXELS = 65536,
   parameter int FRAC_BITS    = 8,
   localparam int ADDR_W = $clog2(IMAGE_PIXELS)
) (
   input  logic                 clock,
   input  addr_ctl_type         ctl,
   input  logic                 mode,
   input  logic [INDEX_W-1:0]   pixel_index,
   input  logic [CHAN_W-1:0]    red_in,
   input  logic [CHAN_W-1:0]    green_in,
   input  logic [CHAN_W-1:0]    blue_in,
   input  logic [COORD_W-1:0]   x_pos,
   input  logic [COORD_W-1:0]   y_pos,
   input  logic [DIM_W-1:0]     frame_width,
   input  logic [DIM_W-1:0]     frame_height,
   output logic [ADDR_W-1:0]    rd_addr [NUM_NEIGHBORS],
   output logic                 bad,
   output logic [FRAC_BITS-1:0] frac_x,
   output logic [FRAC_BITS-1:0] frac_y,
   output logic [ADDR_W-1:0]    wr_addr,
   output pixel_type            wr_data,
   output s3_status_type        status
);

   localparam int IW    = COORD_W - FRAC_BITS;
   localparam int PIX_W = $clog2(IMAGE_PIXELS) + 1;
   localparam int SUM_W = (IW + 10 > PIX_W) ? IW + 10 : PIX_W;
   localparam int CW    = (IW > DIM_W) ? IW + 1 : DIM_W + 1;
   localparam int ICW   = (INDEX_W + 1 > PIX_W) ? INDEX_W + 1 : PIX_W;

   // Stage one.
   logic                 s1_mode_ff;
   logic [INDEX_W-1:0]   s1_index_ff;
   pixel_type            s1_pixel_ff;
   logic [IW-1:0]        s1_lx_ff, s1_ly_ff;
   logic [FRAC_BITS-1:0] s1_fx_ff, s1_fy_ff;

   // Stage two.
   logic                 s2_mode_ff, s2_wr_ok_ff, s2_xbad_ff, s2_ybad_ff;
   logic [INDEX_W-1:0]   s2_index_ff;
   pixel_type            s2_pixel_ff;
   logic [SUM_W-1:0]     s2_prod_ff, s2_lx_ff, s2_lx1_ff, s2_lxw_ff, s2_lxw1_ff;
   logic [FRAC_BITS-1:0] s2_fx_ff, s2_fy_ff;
   logic                 s2_wr_ok_in, s2_xbad_in, s2_ybad_in;

   // Stage three.
   logic [ADDR_W-1:0]    s3_addr_ff [NUM_NEIGHBORS];
   logic [SUM_W-1:0]     s3_addr_in [NUM_NEIGHBORS];
   logic                 s3_bad_ff, s3_bad_in;
   logic [FRAC_BITS-1:0] s3_fx_ff, s3_fy_ff;
   logic [ADDR_W-1:0]    s3_wr_addr_ff;
   pixel_type            s3_pixel_ff;
   s3_status_type        s3_status_ff;

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         s1_mode_ff  <= mode;
         s1_index_ff <= pixel_index;
         s1_pixel_ff <= {red_in, green_in, blue_in};
         s1_lx_ff    <= x_pos[COORD_W-1:FRAC_BITS];
         s1_ly_ff    <= y_pos[COORD_W-1:FRAC_BITS];
         s1_fx_ff    <= x_pos[FRAC_BITS-1:0];
         s1_fy_ff    <= y_pos[FRAC_BITS-1:0];
      end
   end

   always_comb begin
      s2_xbad_in  = (CW'(s1_lx_ff) + CW'(1)) >= CW'(frame_width);
      s2_ybad_in  = (CW'(s1_ly_ff) + CW'(1)) >= CW'(frame_height);
      s2_wr_ok_in = (s1_mode_ff == MODE_WRITE) &&
                    (ICW'(s1_index_ff) < ICW'(IMAGE_PIXELS));
   end

   always_ff @(posedge clock) begin
      if (ctl.s2_en) begin
         s2_prod_ff  <= SUM_W'(s1_ly_ff) * SUM_W'(frame_width);
         s2_lx_ff    <= SUM_W'(s1_lx_ff);
         s2_lx1_ff   <= SUM_W'(s1_lx_ff) + SUM_W'(1);
         s2_lxw_ff   <= SUM_W'(s1_lx_ff) + SUM_W'(frame_width);
         s2_lxw1_ff  <= SUM_W'(s1_lx_ff) + SUM_W'(frame_width) + SUM_W'(1);
         s2_xbad_ff  <= s2_xbad_in;
         s2_ybad_ff  <= s2_ybad_in;
         s2_wr_ok_ff <= s2_wr_ok_in;
         s2_mode_ff  <= s1_mode_ff;
         s2_index_ff <= s1_index_ff;
         s2_pixel_ff <= s1_pixel_ff;
         s2_fx_ff    <= s1_fx_ff;
         s2_fy_ff    <= s1_fy_ff;
      end
   end

   // Neighbor order: (x,y), (x+1,y), (x,y+1), (x+1,y+1). The last one is the
   // largest address, so checking it covers the whole store bound.
   always_comb begin
      s3_addr_in[0] = s2_prod_ff + s2_lx_ff;
      s3_addr_in[1] = s2_prod_ff + s2_lx1_ff;
      s3_addr_in[2] = s2_prod_ff + s2_lxw_ff;
      s3_addr_in[3] = s2_prod_ff + s2_lxw1_ff;
      s3_bad_in     = s2_xbad_ff || s2_ybad_ff ||
                      (s3_addr_in[3] >= SUM_W'(IMAGE_PIXELS));
   end

   always_ff @(posedge clock) begin
      if (ctl.s3_en) begin
         for (int k = 0; k < NUM_NEIGHBORS; k++) begin
            s3_addr_ff[k] <= s3_addr_in[k][ADDR_W-1:0];
         end
         s3_bad_ff              <= s3_bad_in;
         s3_fx_ff               <= s2_fx_ff;
         s3_fy_ff               <= s2_fy_ff;
         s3_wr_addr_ff          <= ADDR_W'(s2_index_ff);
         s3_pixel_ff            <= s2_pixel_ff;
         s3_status_ff.is_sample <= (s2_mode_ff == MODE_SAMPLE);
         s3_status_ff.wr_ok     <= s2_wr_ok_ff;
      end
   end

   assign rd_addr = s3_addr_ff;
   assign bad     = s3_bad_ff;
   assign frac_x  = s3_fx_ff;
   assign frac_y  = s3_fy_ff;
   assign wr_addr = s3_wr_addr_ff;
   assign wr_data = s3_pixel_ff;
   assign status  = s3_status_ff;

endmodule

@@ design/bls_blend.sv @@
// ============================================================================
// bls_blend: bilinear weighting and rounding
// Stages four to six: weights, weight times channel, sum and round to Q8.8.
// ============================================================================
module bls_blend
   import bls_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic                 clock,
   input  blend_ctl_type        ctl,
   input  logic [FRAC_BITS-1:0] frac_x,
   input  logic [FRAC_BITS-1:0] frac_y,
   input  logic                 bad,
   input  pixel_type            px [NUM_NEIGHBORS],
   output logic [OUT_W-1:0]     red_out,
   output logic [OUT_W-1:0]     green_out,
   output logic [OUT_W-1:0]     blue_out,
   output logic                 out_of_range
);

   localparam int W_W   = 2 * FRAC_BITS + 1;
   localparam int M_W   = 2 * FRAC_BITS + 2;
   localparam int P_W   = W_W + CHAN_W;
   localparam int ACC_W = 2 * FRAC_BITS + CHAN_W;
   localparam int SUM_W = ACC_W + 2;
   localparam int SHIFT = 2 * FRAC_BITS - QOUT_FRAC;
   localparam logic [FRAC_BITS:0] SCALE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [FRAC_BITS:0] sfx, sfy;
   logic [M_W-1:0]     mul_full [NUM_NEIGHBORS];
   logic [W_W-1:0]     w_ff [NUM_NEIGHBORS];
   logic               s4_bad_ff;

   logic [P_W-1:0]     prod_full [COLOR_CHANNELS][NUM_NEIGHBORS];
   logic [ACC_W-1:0]   p_ff [COLOR_CHANNELS][NUM_NEIGHBORS];
   logic               s5_bad_ff;

   logic [SUM_W-1:0]   sum_in [COLOR_CHANNELS];
   logic [OUT_W-1:0]   q_in [COLOR_CHANNELS];
   logic [OUT_W-1:0]   out_ff [COLOR_CHANNELS];
   logic               oor_ff;

   // Weights in units of 2^-2F; they always sum to one.
   always_comb begin
      sfx         = SCALE - {1'b0, frac_x};
      sfy         = SCALE - {1'b0, frac_y};
      mul_full[0] = M_W'(sfx) * M_W'(sfy);
      mul_full[1] = M_W'(frac_x) * M_W'(sfy);
      mul_full[2] = M_W'(sfx) * M_W'(frac_y);
      mul_full[3] = M_W'(frac_x) * M_W'(frac_y);
   end

   always_ff @(posedge clock) begin
      if (ctl.s4_en) begin
         for (int k = 0; k < NUM_NEIGHBORS; k++) begin
            w_ff[k] <= mul_full[k][W_W-1:0];
         end
         s4_bad_ff <= bad;
      end
   end

   // Each product is at most 255 * 2^2F and fits ACC_W bits.
   always_comb begin
      for (int ch = 0; ch < COLOR_CHANNELS; ch++) begin
         for (int k = 0; k < NUM_NEIGHBORS; k++) begin
            prod_full[ch][k] = P_W'(w_ff[k]) * P_W'(channel_of(px[k], ch));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s5_en) begin
         for (int ch = 0; ch < COLOR_CHANNELS; ch++) begin
            for (int k = 0; k < NUM_NEIGHBORS; k++) begin
               p_ff[ch][k] <= prod_full[ch][k][ACC_W-1:0];
            end
         end
         s5_bad_ff <= s4_bad_ff;
      end
   end

   always_comb begin
      for (int ch = 0; ch < COLOR_CHANNELS; ch++) begin
         sum_in[ch] = SUM_W'(p_ff[ch][0]) + SUM_W'(p_ff[ch][1]) +
                      SUM_W'(p_ff[ch][2]) + SUM_W'(p_ff[ch][3]);
      end
   end

   generate
      if (SHIFT > 0) begin : g_round
         // Round half up, then drop the extra fraction bits.
         localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (SHIFT - 1);
         logic [SUM_W-1:0] rsum [COLOR_CHANNELS];
         always_comb begin
            for (int ch = 0; ch < COLOR_CHANNELS; ch++) begin
               rsum[ch] = sum_in[ch] + RND;
               q_in[ch] = rsum[ch][SHIFT +: OUT_W];
            end
         end
      end else begin : g_exact
         // Few fraction bits: the sum is widened exactly.
         always_comb begin
            for (int ch = 0; ch < COLOR_CHANNELS; ch++) begin
               q_in[ch] = OUT_W'(sum_in[ch]) << (-SHIFT);
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (ctl.s6_en) begin
         for (int ch = 0; ch < COLOR_CHANNELS; ch++) begin
            out_ff[ch] <= s5_bad_ff ? '0 : q_in[ch];
         end
         oor_ff <= s5_bad_ff;
      end
   end

   assign red_out      = out_ff[0];
   assign green_out    = out_ff[1];
   assign blue_out     = out_ff[2];
   assign out_of_range = oor_ff;

endmodule

@@ design/bilinear_rgb_sampler.sv @@
// ============================================================================
// bilinear_rgb_sampler: RGB pixel store with bilinear sampling
// Write words fill the store, sample words return the bilinear blend of
// the four neighbors of a fixed-point coordinate in Q8.8 per channel.
// ============================================================================
//
//   Channel   Direction  Handshake            Word
//   req_*     in         req_valid/req_stall  mode, index, RGB, x, y
//   rsp_*     out        rsp_valid/rsp_stall  R, G, B in Q8.8, range flag
//   csr_*     in         csr_valid/csr_ready  register index, data
//
// The block takes one word per clock cycle while req_stall is low. A sample
// passes stages one to six and its result sits in the stage six output
// register on the rsp_* ports; a write reaches the store as it leaves stage
// three and returns nothing. The rate is set by the four copies of the
// pixel store, which serve the four neighbor reads together.
// Reset is synchronous and clears the stage valid bits and sets width and
// height to 256. The store has no clearing pass and holds garbage until
// written. Each stage moves when the one after it is empty or moving, so a
// stalled result still lets the stages behind it close up their bubbles.
//
module bilinear_rgb_sampler
   import bls_pkg::*;
#(
   parameter int IMAGE_PIXELS = 65536,
   parameter int FRAC_BITS    = 8
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic [INDEX_W-1:0]     req_pixel_index,
   input  logic [CHAN_W-1:0]      req_red_in,
   input  logic [CHAN_W-1:0]      req_green_in,
   input  logic [CHAN_W-1:0]      req_blue_in,
   input  logic [COORD_W-1:0]     req_x_pos,
   input  logic [COORD_W-1:0]     req_y_pos,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [OUT_W-1:0]       rsp_red_out,
   output logic [OUT_W-1:0]       rsp_green_out,
   output logic [OUT_W-1:0]       rsp_blue_out,
   output logic                   rsp_out_of_range,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_data
);

   localparam int ADDR_W = $clog2(IMAGE_PIXELS);

   // Configuration registers. Writes are taken in any cycle.
   logic [DIM_W-1:0] frame_width_ff, frame_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_RESET;
         frame_height_ff <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage valid bits and load enables. Stage k loads when it is empty or
   // when stage k+1 loads; the last stage is the output register.
   logic [NUM_STAGES:1] stage_valid_ff, stage_valid_in, stage_en;
   s3_status_type       s3_status;
   addr_ctl_type        addr_ctl;
   blend_ctl_type       blend_ctl;

   always_comb begin
      stage_en[NUM_STAGES] = !stage_valid_ff[NUM_STAGES] || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         stage_en[k] = !stage_valid_ff[k] || stage_en[k+1];
      end
   end

   // Writes finish at the store and leave the pipeline after stage three.
   always_comb begin
      stage_valid_in[1] = req_valid;
      stage_valid_in[2] = stage_valid_ff[1];
      stage_valid_in[3] = stage_valid_ff[2];
      stage_valid_in[4] = stage_valid_ff[3] && s3_status.is_sample;
      stage_valid_in[5] = stage_valid_ff[4];
      stage_valid_in[6] = stage_valid_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               stage_valid_ff[k] <= stage_valid_in[k];
            end
         end
      end
   end

   assign req_stall = !stage_en[1];
   assign rsp_valid = stage_valid_ff[NUM_STAGES];

   assign addr_ctl.s1_en  = stage_en[1];
   assign addr_ctl.s2_en  = stage_en[2];
   assign addr_ctl.s3_en  = stage_en[3];
   assign blend_ctl.s4_en = stage_en[4];
   assign blend_ctl.s5_en = stage_en[5];
   assign blend_ctl.s6_en = stage_en[6];

   // Address generation, stages one to three.
   logic [ADDR_W-1:0]    nb_addr [NUM_NEIGHBORS];
   logic                 s3_bad;
   logic [FRAC_BITS-1:0] s3_frac_x, s3_frac_y;
   logic [ADDR_W-1:0]    wr_addr;
   pixel_type            wr_data;
   logic                 wr_en;
   pixel_type            nb_pixel [NUM_NEIGHBORS];

   bls_addr_gen #(
      .IMAGE_PIXELS (IMAGE_PIXELS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_addr_gen (
      .clock        (clock),
      .ctl          (addr_ctl),
      .mode         (req_mode),
      .pixel_index  (req_pixel_index),
      .red_in       (req_red_in),
      .green_in     (req_green_in),
      .blue_in      (req_blue_in),
      .x_pos        (req_x_pos),
      .y_pos        (req_y_pos),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .rd_addr      (nb_addr),
      .bad          (s3_bad),
      .frac_x       (s3_frac_x),
      .frac_y       (s3_frac_y),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .status       (s3_status)
   );

   // The store is kept in four identical copies, one per neighbor. A write
   // goes to all of them as it leaves stage three; a sample reads all four
   // as it enters stage four. Only one word sits in stage three, so a read
   // always sees every write accepted before it.
   assign wr_en = stage_en[4] && stage_valid_ff[3] && s3_status.wr_ok;

   for (genvar k = 0; k < NUM_NEIGHBORS; k++) begin : g_bank
      bls_pixel_bank #(
         .DEPTH   (IMAGE_PIXELS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (stage_en[4]),
         .rd_addr (nb_addr[k]),
         .rd_data (nb_pixel[k])
      );
   end

   // Weighting and rounding, stages four to six.
   bls_blend #(
      .FRAC_BITS    (FRAC_BITS)
   ) u_blend (
      .clock        (clock),
      .ctl          (blend_ctl),
      .frac_x       (s3_frac_x),
      .frac_y       (s3_frac_y),
      .bad          (s3_bad),
      .px           (nb_pixel),
      .red_out      (rsp_red_out),
      .green_out    (rsp_green_out),
      .blue_out     (rsp_blue_out),
      .out_of_range (rsp_out_of_range)
   );

   // The input is held off only when every stage holds a word.
   a_stall_only_when_full : assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> (&stage_valid_ff)
   ) else $error("input stalled while the pipeline has a bubble");

   // A word in stage three that cannot move on stays there.
   a_stage3_holds : assert property (
      @(posedge clock) disable iff (reset)
      (stage_valid_ff[3] && !stage_en[4]) |=> stage_valid_ff[3]
   ) else $error("word dropped from stage three during a stall");

   // A flagged result carries zero colors.
   a_flag_zero : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
         (rsp_red_out == '0 && rsp_green_out == '0 && rsp_blue_out == '0)
   ) else $error("out-of-range result with nonzero colors");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the bilinear RGB sampler
// Drives pixel writes and sample words with random gaps and result
// stalls, predicts each blended result in the bench, and compares every
// returned word field by field against the oldest pending prediction.
// ============================================================================
module tb_top
   import bls_pkg::*;
();

   localparam int STORE_PIXELS = 65536;
   localparam int FRAC         = 8;
   localparam int ONE          = 1 << FRAC;
   // Shift that brings the exact weighted sum down to Q8.8.
   localparam int Q_SHIFT      = 2 * FRAC - QOUT_FRAC;
   // Register index that the block does not implement; writes to it are dropped.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = CSR_INDEX_W'(3);
   localparam int NUM_PHASES   = 8;

   // One result word as the block returns it.
   typedef struct packed {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
      logic             out_of_range;
   } blend_type;

   // One input word, plus an optional hand-written expectation.
   typedef struct {
      logic               mode;
      logic [INDEX_W-1:0] index;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      bit                 typed;
      blend_type          want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_mode = MODE_WRITE;
   logic [INDEX_W-1:0]     req_pixel_index = '0;
   logic [CHAN_W-1:0]      req_red_in = '0;
   logic [CHAN_W-1:0]      req_green_in = '0;
   logic [CHAN_W-1:0]      req_blue_in = '0;
   logic [COORD_W-1:0]     req_x_pos = '0;
   logic [COORD_W-1:0]     req_y_pos = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [OUT_W-1:0]       rsp_red_out;
   logic [OUT_W-1:0]       rsp_green_out;
   logic [OUT_W-1:0]       rsp_blue_out;
   logic                   rsp_out_of_range;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_FRAME_WIDTH;
   logic [DIM_W-1:0]       csr_data = '0;

   // Bench copy of the pixel store and of the two size registers. The
   // written flags keep every sample away from entries that still hold
   // garbage.
   pixel_type pixel_mem [STORE_PIXELS];
   bit        pixel_written [STORE_PIXELS];
   int        img_width  = 256;
   int        img_height = 256;

   blend_type    pending_blends [$];
   stim_row_type directed_rows [$];
   int           fault_count = 0;
   int           words_sent = 0;
   bit           calm = 1'b0;

   // Sizes of the random phases, the extremes and the odd values among them.
   int phase_w     [NUM_PHASES] = '{256, 2, 13, 511, 0, 1, 300, 256};
   int phase_h     [NUM_PHASES] = '{256, 2, 7, 511, 1, 0, 40, 256};
   int phase_words [NUM_PHASES] = '{140, 60, 120, 100, 25, 25, 100, 130};

   bilinear_rgb_sampler #(
      .IMAGE_PIXELS (STORE_PIXELS),
      .FRAC_BITS    (FRAC)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_pixel_index  (req_pixel_index),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // Works out the four neighbor addresses of a coordinate under the
   // current size and returns 1 when any of them lies outside the image
   // or beyond the end of the store.
   function automatic bit neighbor_addrs(input logic [COORD_W-1:0] x, y,
                                         output int a00, a10, a01, a11);
      int lx;
      int ly;
      lx  = int'(x) >> FRAC;
      ly  = int'(y) >> FRAC;
      a00 = ly * img_width + lx;
      a10 = a00 + 1;
      a01 = a00 + img_width;
      a11 = a01 + 1;
      return (lx + 1 >= img_width) || (ly + 1 >= img_height) ||
             (a10 >= STORE_PIXELS) || (a01 >= STORE_PIXELS) || (a11 >= STORE_PIXELS);
   endfunction

   // Bilinear blend of the bench store at one coordinate, per channel in
   // Q8.8 with round half up. A flagged coordinate yields zero colors.
   function automatic blend_type bilinear_blend(input logic [COORD_W-1:0] x, y);
      blend_type        res;
      int               a [4];
      int               wt [4];
      int               fx;
      int               fy;
      int               acc;
      logic [OUT_W-1:0] chan [3];
      res = '0;
      if (neighbor_addrs(x, y, a[0], a[1], a[2], a[3])) begin
         res.out_of_range = 1'b1;
         return res;
      end
      fx    = int'(x) & (ONE - 1);
      fy    = int'(y) & (ONE - 1);
      wt[0] = (ONE - fx) * (ONE - fy);
      wt[1] = fx * (ONE - fy);
      wt[2] = (ONE - fx) * fy;
      wt[3] = fx * fy;
      for (int ch = 0; ch < 3; ch++) begin
         acc = 0;
         for (int k = 0; k < 4; k++) begin
            acc += wt[k] * int'((pixel_mem[a[k]] >> (CHAN_W * (2 - ch))) & 24'hFF);
         end
         chan[ch] = OUT_W'((acc + (1 << (Q_SHIFT - 1))) >> Q_SHIFT);
      end
      res.red   = chan[0];
      res.green = chan[1];
      res.blue  = chan[2];
      return res;
   endfunction

   // Word builders; fields that the word's mode ignores get random values so
   // that every input bit toggles.
   function automatic stim_row_type mk_write(input int idx, input int r, g, b);
      stim_row_type w;
      w.mode  = MODE_WRITE;
      w.index = INDEX_W'(idx);
      w.red   = CHAN_W'(r);
      w.green = CHAN_W'(g);
      w.blue  = CHAN_W'(b);
      w.x     = COORD_W'($urandom);
      w.y     = COORD_W'($urandom);
      w.typed = 1'b0;
      w.want  = '0;
      return w;
   endfunction

   function automatic stim_row_type mk_sample(input int x, y);
      stim_row_type w;
      w      = mk_write($urandom, $urandom, $urandom, $urandom);
      w.mode = MODE_SAMPLE;
      w.x    = COORD_W'(x);
      w.y    = COORD_W'(y);
      return w;
   endfunction

   function automatic stim_row_type mk_known(input int x, y, r, g, b, input bit oor);
      stim_row_type w;
      w       = mk_sample(x, y);
      w.typed = 1'b1;
      w.want  = '{red: OUT_W'(r), green: OUT_W'(g), blue: OUT_W'(b), out_of_range: oor};
      return w;
   endfunction

   // Appends one row to the directed table.
   task automatic add_row(input stim_row_type w);
      directed_rows.insert(directed_rows.size(), w);
   endtask

   // Fraction with a bias toward the two ends of its range.
   function automatic int rand_frac();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15)
         return 0;
      if (r < 25)
         return ONE - 1;
      return $urandom_range(0, ONE - 1);
   endfunction

   // Most gaps are short, a few are long; calm phases send back to back.
   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("%s", msg);
   endtask

   // Sends one word and returns at the edge that accepts it. A write goes
   // into the bench store and a sample queues its expected blend as the word
   // is presented; nothing else is presented until it is taken, so the bench
   // store always sees the words in the block's order.
   task automatic put_word(input stim_row_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= w.mode;
      req_pixel_index <= w.index;
      req_red_in      <= w.red;
      req_green_in    <= w.green;
      req_blue_in     <= w.blue;
      req_x_pos       <= w.x;
      req_y_pos       <= w.y;
      if (w.mode == MODE_WRITE) begin
         pixel_mem[w.index]     = {w.red, w.green, w.blue};
         pixel_written[w.index] = 1'b1;
      end else begin
         pending_blends.insert(pending_blends.size(),
                               w.typed ? w.want : bilinear_blend(w.x, w.y));
      end
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      words_sent++;
   endtask

   // A sample inside the image first fills any neighbor that has never been
   // written, so no read ever lands on an entry that still holds garbage.
   task automatic issue_sample(input logic [COORD_W-1:0] x, y);
      int a [4];
      if (!neighbor_addrs(x, y, a[0], a[1], a[2], a[3])) begin
         foreach (a[k]) begin
            if (!pixel_written[a[k]])
               put_word(mk_write(a[k], $urandom, $urandom, $urandom));
         end
      end
      put_word(mk_sample(x, y));
   endtask

   // Size registers change only with the block drained: no word in flight,
   // no result owed, and a further wait for a trailing write to land.
   task automatic set_image_size(input int w, h, input bit poke_spare);
      logic [CSR_INDEX_W-1:0] idx [3];
      logic [DIM_W-1:0]       val [3];
      int                     n;
      idx[0] = REG_FRAME_WIDTH;
      val[0] = DIM_W'(w);
      idx[1] = REG_FRAME_HEIGHT;
      val[1] = DIM_W'(h);
      idx[2] = REG_SPARE;
      val[2] = DIM_W'($urandom);
      n = poke_spare ? 3 : 2;
      req_valid <= 1'b0;
      while (pending_blends.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 2) @(posedge clock);
      for (int i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         @(posedge clock);
         while (csr_ready !== 1'b1) @(posedge clock);
         if (idx[i] == REG_FRAME_WIDTH)
            img_width = int'(val[i]);
         else if (idx[i] == REG_FRAME_HEIGHT)
            img_height = int'(val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // One step of the random part. Most steps are samples inside the image,
   // usually in a small corner so that pixels get reused and overwritten;
   // the rest are full-range coordinates and stray writes.
   task automatic random_step(inout logic [COORD_W-1:0] last_x, last_y);
      int  r;
      int  lx;
      int  ly;
      int  lx_top;
      int  ly_top;
      int  a [4];
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      r = $urandom_range(0, 99);
      if (r < 50 && img_width >= 2 && img_height >= 2) begin
         lx_top = (img_width - 2 < 255) ? img_width - 2 : 255;
         lx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, (lx_top < 7) ? lx_top : 7)
                                          : $urandom_range(0, lx_top);
         ly_top = (img_height - 2 < 255) ? img_height - 2 : 255;
         if ((65534 - lx) / img_width - 1 < ly_top)
            ly_top = (65534 - lx) / img_width - 1;
         ly = ($urandom_range(0, 9) < 7) ? $urandom_range(0, (ly_top < 7) ? ly_top : 7)
                                          : $urandom_range(0, ly_top);
         x = COORD_W'((lx << FRAC) | rand_frac());
         y = COORD_W'((ly << FRAC) | rand_frac());
         issue_sample(x, y);
         last_x = x;
         last_y = y;
      end else if (r < 62) begin
         // Overwrite one neighbor of the previous sample and sample the same
         // cell again right behind it, which hits the write-to-read hazard.
         if (!neighbor_addrs(last_x, last_y, a[0], a[1], a[2], a[3]))
            put_word(mk_write(a[$urandom_range(0, 3)], $urandom, $urandom, $urandom));
         x = COORD_W'((int'(last_x) & ~(ONE - 1)) | rand_frac());
         y = COORD_W'((int'(last_y) & ~(ONE - 1)) | rand_frac());
         issue_sample(x, y);
      end else if (r < 78) begin
         issue_sample(COORD_W'($urandom), COORD_W'($urandom));
      end else if (r < 90) begin
         put_word(mk_write($urandom_range(0, 1023), $urandom, $urandom, $urandom));
      end else begin
         put_word(mk_write($urandom_range(0, STORE_PIXELS - 1), $urandom, $urandom, $urandom));
      end
   endtask

   // Result stalls: runs of free flow, short stalls and a few long ones.
   initial begin
      int   r;
      int   run;
      logic lvl;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            lvl = 1'b0;
            run = $urandom_range(1, 40);
         end else if (r < 85) begin
            lvl = 1'b1;
            run = $urandom_range(1, 3);
         end else begin
            lvl = 1'b1;
            run = $urandom_range(8, 40);
         end
         @(posedge clock);
         rsp_stall <= lvl;
         repeat (run - 1) @(posedge clock);
      end
   end

   // Result checker: every word taken must match the oldest pending blend.
   always @(posedge clock) begin
      blend_type got;
      blend_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = '{red: rsp_red_out, green: rsp_green_out, blue: rsp_blue_out,
                 out_of_range: rsp_out_of_range};
         if (pending_blends.size() == 0) begin
            report_fault($sformatf("unexpected result word r=%0d g=%0d b=%0d oor=%0b",
                                   got.red, got.green, got.blue, got.out_of_range));
         end else begin
            want = pending_blends.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.out_of_range !== want.out_of_range) begin
               report_fault($sformatf(
                  {"result mismatch: expected r=%0d g=%0d b=%0d oor=%0b, ",
                   "got r=%0d g=%0d b=%0d oor=%0b"},
                  want.red, want.green, want.blue, want.out_of_range,
                  got.red, got.green, got.blue, got.out_of_range));
            end
         end
      end
   end

   // Hard limit far above the slowest correct run.
   initial begin
      #(10_000_000);
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [COORD_W-1:0] last_x;
      logic [COORD_W-1:0] last_y;
      int                 phase_end;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset size of 256 by 256. A two by two
      // block in the top left corner holds red, green, blue and white.
      add_row(mk_write(0, 255, 0, 0));
      add_row(mk_write(1, 0, 255, 0));
      add_row(mk_write(256, 0, 0, 255));
      add_row(mk_write(257, 255, 255, 255));
      // A zero fraction returns the top left pixel unchanged.
      add_row(mk_known(16'h0000, 16'h0000, 65280, 0, 0, 1'b0));
      add_row(mk_sample(16'h0080, 16'h0080));
      add_row(mk_sample(16'h00FF, 16'h00FF));
      add_row(mk_sample(16'h00FF, 16'h0000));
      add_row(mk_sample(16'h0000, 16'h00FF));
      // Last column and last row have no right or lower neighbor, even
      // with a zero fraction.
      add_row(mk_known(16'hFF00, 16'h0000, 0, 0, 0, 1'b1));
      add_row(mk_known(16'h0000, 16'hFF00, 0, 0, 0, 1'b1));
      add_row(mk_known(16'hFFFF, 16'hFFFF, 0, 0, 0, 1'b1));
      // The bottom right corner of the store, up to the last address.
      add_row(mk_write(65278, 255, 255, 255));
      add_row(mk_write(65279, 0, 0, 0));
      add_row(mk_write(65534, 170, 85, 15));
      add_row(mk_write(65535, 1, 2, 3));
      add_row(mk_known(16'hFE00, 16'hFE00, 65280, 65280, 65280, 1'b0));
      add_row(mk_sample(16'hFEFF, 16'hFEFF));
      add_row(mk_sample(16'hFE80, 16'hFE00));
      add_row(mk_sample(16'hFE00, 16'hFEFF));
      // Overwrite a pixel and read it back on the very next word.
      add_row(mk_write(0, 0, 0, 0));
      add_row(mk_known(16'h0000, 16'h0000, 0, 0, 0, 1'b0));
      add_row(mk_sample(16'h0001, 16'h0001));

      foreach (directed_rows[i])
         put_word(directed_rows[i]);

      // Random part, one phase per image size. The first phase keeps the
      // reset size; the later ones go through the smallest image, odd sizes,
      // widths that run past the store, and widths or heights that flag
      // every sample.
      last_x = '0;
      last_y = '0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0)
            set_image_size(phase_w[p], phase_h[p], p == 3 || p == 6);
         calm      = ($urandom_range(0, 3) == 0);
         phase_end = words_sent + phase_words[p];
         while (words_sent < phase_end)
            random_step(last_x, last_y);
      end

      // Drain: wait for every owed result, then a little longer so that a
      // stray extra word would still be caught.
      req_valid <= 1'b0;
      while (pending_blends.size() != 0) @(posedge clock);
      repeat (NUM_STAGES * 4) @(posedge clock);

      if (fault_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
